### rtl/plci_pkg.sv
// ----------------------------------------------------------------------------
// plci_pkg
// Shared types, constants and codes of the piecewise-linear curve core.
// ----------------------------------------------------------------------------
package plci_pkg;

  localparam int MAX_POINTS     = 64;
  localparam int ADDR_W         = $clog2(MAX_POINTS);
  localparam int CNT_W          = $clog2(MAX_POINTS + 1);
  localparam int MAX_ITERATIONS = 32;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
  localparam int MUL_STEPS      = 33;
  localparam int DIV_STEPS      = 65;
  localparam int STEP_W         = 7;
  localparam int ENTRY_W        = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_INVERT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FEW    = 3'd1,
    ST_BEYOND = 3'd2,
    ST_FULL   = 3'd3,
    ST_LIMIT  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ANS_ZERO,
    ANS_Y,
    ANS_LO,
    ANS_HI,
    ANS_MID
  } ans_sel_e;

  typedef enum logic [1:0] {
    PRB_LO,
    PRB_HI,
    PRB_MID
  } probe_e;

  typedef enum logic [1:0] {
    RET_EVAL,
    RET_LO,
    RET_HI,
    RET_MID
  } ret_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_EV_START,
    S_EV_RD,
    S_EV_CHK,
    S_MUL,
    S_DIV_INIT,
    S_DIV,
    S_SAT,
    S_RET,
    S_INV_CHK
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] x_value;
    logic [31:0] y_value;
    logic [30:0] tolerance;
    logic [31:0] low_bound;
    logic [31:0] high_bound;
  } in_t;

  typedef struct packed {
    logic [31:0]      answer;
    logic [31:0]      new_low;
    logic [31:0]      new_high;
    logic [2:0]       status;
    logic [CNT_W-1:0] point_count;
  } out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     load;
    logic     idx_clr;
    logic     idx_inc;
    logic     idx_dec;
    logic     pos_ld;
    logic     rd_prev;
    logic     wr_shift;
    logic     wr_put;
    logic     cnt_inc;
    logic     probe_ld;
    probe_e   probe_sel;
    logic     prev_ld;
    logic     y_match;
    logic     mul_start;
    logic     mul_step;
    logic     div_start;
    logic     div_step;
    logic     y_sat;
    logic     ylo_ld;
    logic     yhi_ld;
    logic     inv_upd;
    logic     iter_clr;
    logic     iter_inc;
    logic     fin;
    ans_sel_e ans_sel;
    logic     fin_bounds;
    status_e  fin_status;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    cmd_e command;
    logic idx_at_cnt;
    logic idx_at_pos;
    logic idx_zero;
    logic full;
    logic few;
    logic key_eq;
    logic key_gt;
    logic mul_last;
    logic div_last;
    logic lo_hit;
    logic hi_hit;
    logic span_low;
    logic iter_last;
  } dp_stat_t;

endpackage

### rtl/piecewise_linear_curve_inverse_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_inverse_core
// Sorted curve-point table with insert, linear evaluate and bisection inverse.
// ----------------------------------------------------------------------------
// Insert scans for the insert position, then shifts entries up one by one
//   through the registered-read table port; evaluate scans, then runs the
//   33-step multiply and 65-step divide; invert runs up to MAX_ITERATIONS+2
//   evaluations, each with its own scan.
// One command at a time; busy stays high until the result beat but for CMD_NONE.
// Reset clears the point count; table contents are undefined until written.
module piecewise_linear_curve_inverse_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  plci_pkg::in_t  in_i,
  output logic           done_o,
  output plci_pkg::out_t res_o
);

  plci_pkg::dp_cmd_t  dp_cmd;
  plci_pkg::dp_stat_t dp_stat;

  plci_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .stat_i(dp_stat),
    .cmd_o (dp_cmd)
  );

  plci_dpath u_dpath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .cmd_i (dp_cmd),
    .stat_o(dp_stat),
    .done_o(done_o),
    .res_o (res_o)
  );

endmodule

### rtl/plci_ram.sv
// ----------------------------------------------------------------------------
// plci_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module plci_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/plci_ctrl.sv
// ----------------------------------------------------------------------------
// plci_ctrl
// Command sequencer: table scan, insert shift, evaluate and bisection loop.
// ----------------------------------------------------------------------------
module plci_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  plci_pkg::dp_stat_t stat_i,
  output plci_pkg::dp_cmd_t  cmd_o
);

  plci_pkg::state_e  state_q, state_d;
  plci_pkg::ret_e    ret_q, ret_d;
  plci_pkg::status_e evst_q, evst_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plci_pkg::S_IDLE;
      ret_q   <= plci_pkg::RET_EVAL;
      evst_q  <= plci_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      evst_q  <= evst_d;
    end
  end

  assign busy = (state_q != plci_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    evst_d  = evst_q;
    cmd_o   = '0;
    cmd_o.probe_sel  = plci_pkg::PRB_MID;
    cmd_o.ans_sel    = plci_pkg::ANS_ZERO;
    cmd_o.fin_status = plci_pkg::ST_OK;
    unique case (state_q)
      plci_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          unique case (stat_i.command)
            plci_pkg::CMD_INSERT: state_d = plci_pkg::S_INS_RD;
            plci_pkg::CMD_EVAL: begin
              ret_d   = plci_pkg::RET_EVAL;
              state_d = plci_pkg::S_EV_START;
            end
            plci_pkg::CMD_INVERT: begin
              ret_d   = plci_pkg::RET_LO;
              state_d = plci_pkg::S_EV_START;
            end
            default: cmd_o.fin = 1'b1;
          endcase
        end
      end
      // insert: look for a duplicate or the insert position
      plci_pkg::S_INS_RD: begin
        if (stat_i.idx_at_cnt) begin
          if (stat_i.full) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = plci_pkg::ST_FULL;
            state_d          = plci_pkg::S_IDLE;
          end else begin
            cmd_o.pos_ld = 1'b1;
            state_d      = plci_pkg::S_SH_RD;
          end
        end else begin
          state_d = plci_pkg::S_INS_CHK;
        end
      end
      plci_pkg::S_INS_CHK: begin
        if (stat_i.key_eq) begin
          cmd_o.fin = 1'b1;
          state_d   = plci_pkg::S_IDLE;
        end else if (stat_i.key_gt) begin
          if (stat_i.full) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = plci_pkg::ST_FULL;
            state_d          = plci_pkg::S_IDLE;
          end else begin
            cmd_o.pos_ld = 1'b1;
            state_d      = plci_pkg::S_SH_RD;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = plci_pkg::S_INS_RD;
        end
      end
      // shift entries up by one, from the top down to the insert position
      plci_pkg::S_SH_RD: begin
        if (stat_i.idx_at_pos) begin
          state_d = plci_pkg::S_PUT;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = plci_pkg::S_SH_WR;
        end
      end
      plci_pkg::S_SH_WR: begin
        cmd_o.rd_prev  = 1'b1;
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_dec  = 1'b1;
        state_d        = plci_pkg::S_SH_RD;
      end
      plci_pkg::S_PUT: begin
        cmd_o.wr_put  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.fin     = 1'b1;
        state_d       = plci_pkg::S_IDLE;
      end
      // evaluate subroutine
      plci_pkg::S_EV_START: begin
        cmd_o.idx_clr = 1'b1;
        if (stat_i.few) begin
          evst_d  = plci_pkg::ST_FEW;
          state_d = plci_pkg::S_RET;
        end else begin
          state_d = plci_pkg::S_EV_RD;
        end
      end
      plci_pkg::S_EV_RD: begin
        if (stat_i.idx_at_cnt) begin
          evst_d  = plci_pkg::ST_BEYOND;
          state_d = plci_pkg::S_RET;
        end else begin
          state_d = plci_pkg::S_EV_CHK;
        end
      end
      plci_pkg::S_EV_CHK: begin
        if (stat_i.key_eq) begin
          cmd_o.y_match = 1'b1;
          evst_d        = plci_pkg::ST_OK;
          state_d       = plci_pkg::S_RET;
        end else if (stat_i.key_gt && !stat_i.idx_zero) begin
          cmd_o.mul_start = 1'b1;
          state_d         = plci_pkg::S_MUL;
        end else begin
          cmd_o.prev_ld = 1'b1;
          cmd_o.idx_inc = 1'b1;
          state_d       = plci_pkg::S_EV_RD;
        end
      end
      plci_pkg::S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.mul_last) begin
          state_d = plci_pkg::S_DIV_INIT;
        end
      end
      plci_pkg::S_DIV_INIT: begin
        cmd_o.div_start = 1'b1;
        state_d         = plci_pkg::S_DIV;
      end
      plci_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = plci_pkg::S_SAT;
        end
      end
      plci_pkg::S_SAT: begin
        cmd_o.y_sat = 1'b1;
        evst_d      = plci_pkg::ST_OK;
        state_d     = plci_pkg::S_RET;
      end
      // return from evaluate to its caller
      plci_pkg::S_RET: begin
        if (ret_q == plci_pkg::RET_EVAL) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = evst_q;
          cmd_o.ans_sel    = (evst_q == plci_pkg::ST_OK) ? plci_pkg::ANS_Y
                                                         : plci_pkg::ANS_ZERO;
          state_d          = plci_pkg::S_IDLE;
        end else if (evst_q != plci_pkg::ST_OK) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = evst_q;
          cmd_o.fin_bounds = 1'b1;
          state_d          = plci_pkg::S_IDLE;
        end else begin
          unique case (ret_q)
            plci_pkg::RET_LO: begin
              cmd_o.ylo_ld    = 1'b1;
              cmd_o.probe_ld  = 1'b1;
              cmd_o.probe_sel = plci_pkg::PRB_HI;
              ret_d           = plci_pkg::RET_HI;
              state_d         = plci_pkg::S_EV_START;
            end
            plci_pkg::RET_HI: begin
              cmd_o.yhi_ld    = 1'b1;
              cmd_o.iter_clr  = 1'b1;
              cmd_o.probe_ld  = 1'b1;
              cmd_o.probe_sel = plci_pkg::PRB_MID;
              ret_d           = plci_pkg::RET_MID;
              state_d         = plci_pkg::S_EV_START;
            end
            default: begin
              cmd_o.inv_upd = 1'b1;
              state_d       = plci_pkg::S_INV_CHK;
            end
          endcase
        end
      end
      // bisection stop checks
      plci_pkg::S_INV_CHK: begin
        cmd_o.fin_bounds = 1'b1;
        priority if (stat_i.lo_hit) begin
          cmd_o.fin     = 1'b1;
          cmd_o.ans_sel = plci_pkg::ANS_LO;
          state_d       = plci_pkg::S_IDLE;
        end else if (stat_i.hi_hit) begin
          cmd_o.fin     = 1'b1;
          cmd_o.ans_sel = plci_pkg::ANS_HI;
          state_d       = plci_pkg::S_IDLE;
        end else if (stat_i.span_low) begin
          cmd_o.fin     = 1'b1;
          cmd_o.ans_sel = plci_pkg::ANS_MID;
          state_d       = plci_pkg::S_IDLE;
        end else if (stat_i.iter_last) begin
          cmd_o.fin        = 1'b1;
          cmd_o.ans_sel    = plci_pkg::ANS_MID;
          cmd_o.fin_status = plci_pkg::ST_LIMIT;
          state_d          = plci_pkg::S_IDLE;
        end else begin
          cmd_o.iter_inc  = 1'b1;
          cmd_o.probe_ld  = 1'b1;
          cmd_o.probe_sel = plci_pkg::PRB_MID;
          state_d         = plci_pkg::S_EV_START;
        end
      end
      default: state_d = plci_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/plci_dpath.sv
// ----------------------------------------------------------------------------
// plci_dpath
// Datapath: point table, scan index, serial multiplier and divider,
// bisection bracket and result register.
// ----------------------------------------------------------------------------
module plci_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plci_pkg::in_t      in_i,
  input  plci_pkg::dp_cmd_t  cmd_i,
  output plci_pkg::dp_stat_t stat_o,
  output logic               done_o,
  output plci_pkg::out_t     res_o
);

  localparam logic [plci_pkg::CNT_W-1:0] FullCount = plci_pkg::CNT_W'(plci_pkg::MAX_POINTS);

  // control registers
  logic [plci_pkg::CNT_W-1:0]  count_q, idx_q, pos_q;
  logic [plci_pkg::ITER_W-1:0] iter_q;
  logic [plci_pkg::STEP_W-1:0] step_q;
  logic                        done_q;

  // payload registers
  logic [31:0] ex_q, y_q, lo_q, hi_q, yv_q, ylo_q, yhi_q, y0_q, d_q;
  logic [30:0] tol_q;
  logic [63:0] prev_q;
  logic [32:0] a_q, rem_q;
  logic [65:0] prod_q;
  logic [64:0] dvd_q;
  logic        neg_q;
  logic [31:0] ans_q, nlo_q, nhi_q;
  logic [2:0]  st_q;

  // table memory
  logic [plci_pkg::CNT_W-1:0]   idx_m1;
  logic [plci_pkg::ADDR_W-1:0]  raddr, waddr;
  logic [plci_pkg::ENTRY_W-1:0] wdata, rdata;
  logic                         we;
  logic [31:0]                  key, val;

  assign idx_m1 = idx_q - 1'b1;
  assign raddr  = cmd_i.rd_prev ? idx_m1[plci_pkg::ADDR_W-1:0]
                                : idx_q[plci_pkg::ADDR_W-1:0];
  assign waddr  = cmd_i.wr_put ? pos_q[plci_pkg::ADDR_W-1:0]
                               : idx_q[plci_pkg::ADDR_W-1:0];
  assign wdata  = cmd_i.wr_put ? {ex_q, y_q} : rdata;
  assign we     = cmd_i.wr_put | cmd_i.wr_shift;
  assign key    = rdata[63:32];
  assign val    = rdata[31:0];

  plci_ram #(
    .WIDTH(plci_pkg::ENTRY_W),
    .DEPTH(plci_pkg::MAX_POINTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // bracket midpoint, floor of the half sum
  logic [32:0] msum;
  logic [31:0] mid;
  assign msum = {lo_q[31], lo_q} + {hi_q[31], hi_q};
  assign mid  = msum[32:1];

  // segment setup from previous and current entry
  logic [32:0] dx, dy, xd, adx, ady;
  assign dx  = {ex_q[31], ex_q} - {prev_q[63], prev_q[63:32]};
  assign dy  = {val[31], val} - {prev_q[31], prev_q[31:0]};
  assign xd  = {key[31], key} - {prev_q[63], prev_q[63:32]};
  assign adx = dx[32] ? -dx : dx;
  assign ady = dy[32] ? -dy : dy;

  // shift-add multiplier step
  logic [33:0] msum_step;
  assign msum_step = {1'b0, prod_q[65:33]} + (prod_q[0] ? {1'b0, a_q} : 34'd0);

  // restoring divider step
  logic [32:0] rsh;
  logic        rge;
  assign rsh = {rem_q[31:0], dvd_q[64]};
  assign rge = (rsh >= {1'b0, d_q});

  // saturating sum of base value and signed quotient
  logic        qbig;
  logic [35:0] qs, ysum;
  logic [31:0] ysat;
  assign qbig = |dvd_q[64:34];
  assign qs   = neg_q ? -{2'b00, dvd_q[33:0]} : {2'b00, dvd_q[33:0]};
  assign ysum = {{4{y0_q[31]}}, y0_q} + qs;
  always_comb begin
    priority if (qbig) begin
      ysat = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if ($signed(ysum) > 36'sh0_7fff_ffff) begin
      ysat = 32'h7fff_ffff;
    end else if ($signed(ysum) < -36'sh0_8000_0000) begin
      ysat = 32'h8000_0000;
    end else begin
      ysat = ysum[31:0];
    end
  end

  // bracket span compare
  logic [32:0] span;
  assign span = {yhi_q[31], yhi_q} - {ylo_q[31], ylo_q};

  // result value select
  logic [31:0] ans_d;
  always_comb begin
    unique case (cmd_i.ans_sel)
      plci_pkg::ANS_Y:   ans_d = yv_q;
      plci_pkg::ANS_LO:  ans_d = lo_q;
      plci_pkg::ANS_HI:  ans_d = hi_q;
      plci_pkg::ANS_MID: ans_d = mid;
      default:           ans_d = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      pos_q   <= '0;
      iter_q  <= '0;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.fin;
      if (cmd_i.cnt_inc) count_q <= count_q + 1'b1;
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.pos_ld) begin
        idx_q <= count_q;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_m1;
      end
      if (cmd_i.pos_ld) pos_q <= idx_q;
      if (cmd_i.iter_clr) begin
        iter_q <= '0;
      end else if (cmd_i.iter_inc) begin
        iter_q <= iter_q + 1'b1;
      end
      if (cmd_i.mul_start || cmd_i.div_start) begin
        step_q <= '0;
      end else if (cmd_i.mul_step || cmd_i.div_step) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ex_q  <= (in_i.command == plci_pkg::CMD_INVERT) ? in_i.low_bound : in_i.x_value;
      y_q   <= in_i.y_value;
      tol_q <= in_i.tolerance;
      lo_q  <= in_i.low_bound;
      hi_q  <= in_i.high_bound;
    end else if (cmd_i.probe_ld) begin
      unique case (cmd_i.probe_sel)
        plci_pkg::PRB_LO: ex_q <= lo_q;
        plci_pkg::PRB_HI: ex_q <= hi_q;
        default:          ex_q <= mid;
      endcase
    end else if (cmd_i.inv_upd) begin
      if ($signed(y_q) > $signed(yv_q)) begin
        lo_q  <= ex_q;
        ylo_q <= yv_q;
      end else begin
        hi_q  <= ex_q;
        yhi_q <= yv_q;
      end
    end
    if (cmd_i.ylo_ld) ylo_q <= yv_q;
    if (cmd_i.yhi_ld) yhi_q <= yv_q;
    if (cmd_i.prev_ld) prev_q <= rdata;
    if (cmd_i.y_match) yv_q <= val;
    if (cmd_i.y_sat) yv_q <= ysat;
    if (cmd_i.mul_start) begin
      a_q    <= adx;
      prod_q <= {33'd0, ady};
      neg_q  <= dx[32] ^ dy[32];
      y0_q   <= prev_q[31:0];
      d_q    <= xd[31:0];
    end else if (cmd_i.mul_step) begin
      prod_q <= {msum_step, prod_q[32:1]};
    end
    if (cmd_i.div_start) begin
      dvd_q <= prod_q[64:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rge ? (rsh - {1'b0, d_q}) : rsh;
      dvd_q <= {dvd_q[63:0], rge};
    end
    if (cmd_i.fin) begin
      ans_q <= ans_d;
      nlo_q <= cmd_i.fin_bounds ? lo_q : 32'd0;
      nhi_q <= cmd_i.fin_bounds ? hi_q : 32'd0;
      st_q  <= cmd_i.fin_status;
    end
  end

  // status to the controller
  assign stat_o.command    = plci_pkg::cmd_e'(in_i.command);
  assign stat_o.idx_at_cnt = (idx_q == count_q);
  assign stat_o.idx_at_pos = (idx_q == pos_q);
  assign stat_o.idx_zero   = (idx_q == '0);
  assign stat_o.full       = (count_q == FullCount);
  assign stat_o.few        = (count_q < plci_pkg::CNT_W'(2));
  assign stat_o.key_eq     = (key == ex_q);
  assign stat_o.key_gt     = ($signed(key) > $signed(ex_q));
  assign stat_o.mul_last   = (step_q == plci_pkg::STEP_W'(plci_pkg::MUL_STEPS - 1));
  assign stat_o.div_last   = (step_q == plci_pkg::STEP_W'(plci_pkg::DIV_STEPS - 1));
  assign stat_o.lo_hit     = (ylo_q == y_q);
  assign stat_o.hi_hit     = (yhi_q == y_q);
  assign stat_o.span_low   = ($signed(span) < $signed({2'b00, tol_q}));
  assign stat_o.iter_last  = (iter_q == plci_pkg::ITER_W'(plci_pkg::MAX_ITERATIONS - 1));

  // result beat
  assign done_o            = done_q;
  assign res_o.answer      = ans_q;
  assign res_o.new_low     = nlo_q;
  assign res_o.new_high    = nhi_q;
  assign res_o.status      = st_q;
  assign res_o.point_count = count_q;

endmodule

### rtl/plci_checker.sv
// ----------------------------------------------------------------------------
// plci_checker
// Port-level checks of the command handshake and result beats.
// ----------------------------------------------------------------------------
module plci_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input plci_pkg::in_t  in_i,
  input logic           done_o,
  input plci_pkg::out_t res_o
);

  // an accepted command holds the core busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.command != plci_pkg::CMD_NONE) |=> busy)
    else $error("core not busy after command");

  // a result beat only appears once the core is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  // an unused command answers on the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.command == plci_pkg::CMD_NONE) |=> done_o)
    else $error("no result beat for unused command");

  // point count never exceeds table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.point_count <= plci_pkg::CNT_W'(plci_pkg::MAX_POINTS))
    else $error("point count out of range");

  // status codes on a beat are defined ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.status <= 3'd4))
    else $error("bad status code");

endmodule

bind piecewise_linear_curve_inverse_core plci_checker u_plci_checker (.*);

### tb/piecewise_linear_curve_inverse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_curve_inverse_checker
// Watches the command and result channels of the curve core, predicts each
// result from its own copy of the point table and compares field by field.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_inverse_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           busy,
  input  plci_pkg::in_t  in_i,
  input  logic           done_o,
  input  plci_pkg::out_t res_o,
  output int             pending_o,
  output int             errors_o,
  output int             checked_o
);

  // shadow of the curve table
  logic signed [31:0] key_tab [plci_pkg::MAX_POINTS];
  logic signed [31:0] val_tab [plci_pkg::MAX_POINTS];
  int                 npoints;
  plci_pkg::out_t     expected_results [$];

  initial begin
    npoints   = 0;
    pending_o = 0;
    errors_o  = 0;
    checked_o = 0;
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor of the average, no overflow in 64 bits
  function automatic longint mid_of(input longint a, input longint b);
    longint s;
    s = a + b;
    return (s >= 0) ? s / 2 : -((-s + 1) / 2);
  endfunction

  // interpolate the curve at x
  function automatic plci_pkg::status_e curve_eval(input longint x, output longint y);
    longint x0, y0, dx, dy;
    longint unsigned d, q, mx, my;
    bit neg;
    y = 0;
    if (npoints < 2) return plci_pkg::ST_FEW;
    for (int i = 0; i < npoints; i++)
      if (key_tab[i] == x) begin
        y = val_tab[i];
        return plci_pkg::ST_OK;
      end
    for (int i = 1; i < npoints; i++)
      if (key_tab[i] > x) begin
        x0  = key_tab[i-1];
        y0  = val_tab[i-1];
        dx  = x - x0;
        dy  = longint'(val_tab[i]) - y0;
        d   = longint'(key_tab[i]) - x0;
        mx  = (dx < 0) ? -dx : dx;
        my  = (dy < 0) ? -dy : dy;
        q   = (mx * my) / d;
        neg = (dx < 0) != (dy < 0);
        if (q > 64'h2_0000_0000) y = neg ? -64'sd2147483648 : 64'sd2147483647;
        else y = sat32(y0 + (neg ? -longint'(q) : longint'(q)));
        return plci_pkg::ST_OK;
      end
    return plci_pkg::ST_BEYOND;
  endfunction

  // sorted insert, duplicates ignored
  function automatic plci_pkg::status_e curve_insert(input longint x, input longint y);
    int pos;
    for (int i = 0; i < npoints; i++)
      if (key_tab[i] == x) return plci_pkg::ST_OK;
    if (npoints >= plci_pkg::MAX_POINTS) return plci_pkg::ST_FULL;
    pos = 0;
    while (pos < npoints && key_tab[pos] < x) pos++;
    for (int i = npoints; i > pos; i--) begin
      key_tab[i] = key_tab[i-1];
      val_tab[i] = val_tab[i-1];
    end
    key_tab[pos] = x[31:0];
    val_tab[pos] = y[31:0];
    npoints++;
    return plci_pkg::ST_OK;
  endfunction

  // bisection toward target
  function automatic plci_pkg::status_e curve_invert(input longint target,
                                                     input longint tol,
                                                     inout longint lo, inout longint hi,
                                                     output longint ans);
    longint ylo, yhi, m, ym;
    plci_pkg::status_e st;
    ans = 0;
    st = curve_eval(lo, ylo);
    if (st != plci_pkg::ST_OK) return st;
    st = curve_eval(hi, yhi);
    if (st != plci_pkg::ST_OK) return st;
    for (int n = 0; n < plci_pkg::MAX_ITERATIONS; n++) begin
      m  = mid_of(lo, hi);
      st = curve_eval(m, ym);
      if (st != plci_pkg::ST_OK) return st;
      if (target > ym) begin
        lo = m; ylo = ym;
      end else begin
        hi = m; yhi = ym;
      end
      if (ylo == target) begin
        ans = lo; return plci_pkg::ST_OK;
      end
      if (yhi == target) begin
        ans = hi; return plci_pkg::ST_OK;
      end
      if (yhi - ylo < tol) begin
        ans = mid_of(lo, hi); return plci_pkg::ST_OK;
      end
    end
    ans = mid_of(lo, hi);
    return plci_pkg::ST_LIMIT;
  endfunction

  function automatic plci_pkg::out_t predict_result(input plci_pkg::in_t it);
    plci_pkg::out_t    r;
    longint            lo, hi, ans;
    plci_pkg::status_e st;
    lo  = 0;
    hi  = 0;
    ans = 0;
    st  = plci_pkg::ST_OK;
    case (plci_pkg::cmd_e'(it.command))
      plci_pkg::CMD_INSERT:
        st = curve_insert($signed(it.x_value), $signed(it.y_value));
      plci_pkg::CMD_EVAL: begin
        st = curve_eval($signed(it.x_value), ans);
        if (st != plci_pkg::ST_OK) ans = 0;
      end
      plci_pkg::CMD_INVERT: begin
        lo = $signed(it.low_bound);
        hi = $signed(it.high_bound);
        st = curve_invert($signed(it.y_value), {33'd0, it.tolerance}, lo, hi, ans);
        if (st != plci_pkg::ST_OK && st != plci_pkg::ST_LIMIT) ans = 0;
      end
      default: ;
    endcase
    r.answer      = ans[31:0];
    r.new_low     = lo[31:0];
    r.new_high    = hi[31:0];
    r.status      = st;
    r.point_count = npoints[plci_pkg::CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    errors_o++;
  endtask

  // compare result beats, then record the accepted command beat
  always @(posedge clk_i) begin
    plci_pkg::out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", res_o.answer, 32'd0);
        end else begin
          want = expected_results.pop_front();
          checked_o++;
          if (res_o.answer !== want.answer)
            report_mismatch("answer", res_o.answer, want.answer);
          if (res_o.new_low !== want.new_low)
            report_mismatch("new_low", res_o.new_low, want.new_low);
          if (res_o.new_high !== want.new_high)
            report_mismatch("new_high", res_o.new_high, want.new_high);
          if (res_o.status !== want.status)
            report_mismatch("status", 32'(res_o.status), 32'(want.status));
          if (res_o.point_count !== want.point_count)
            report_mismatch("point_count", 32'(res_o.point_count), 32'(want.point_count));
        end
      end
      if (start && !busy) expected_results.push_back(predict_result(in_i));
      pending_o = expected_results.size();
    end
  end

endmodule

### tb/piecewise_linear_curve_inverse_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_curve_inverse_core_tb
// Drives inserts, evaluates and inverts into the curve core: a directed
// opening on empty, sparse and saturating tables, then random traffic
// in three phases of sender idling. The checker predicts and compares.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_inverse_core_tb;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int PHASE_ITEMS    = 530;
  localparam int IN_W           = $bits(plci_pkg::in_t);

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  plci_pkg::in_t  in_i   = '0;
  logic           busy;
  logic           done_o;
  plci_pkg::out_t res_o;
  int             pending, errors, checked;
  int             stall_cycles = 0;
  int             cmd_count [4] = '{default: 0};
  int             idle_pct = 0;
  int             key_seen [$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  piecewise_linear_curve_inverse_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  piecewise_linear_curve_inverse_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .in_i      (in_i),
    .done_o    (done_o),
    .res_o     (res_o),
    .pending_o (pending),
    .errors_o  (errors),
    .checked_o (checked)
  );

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one command beat, sometimes with a random gap in front of it
  task automatic send_cmd(input plci_pkg::in_t it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= it;
    cmd_count[it.command]++;
    do @(posedge clk_i); while (busy);
  endtask

  // hold off until every result is back
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic plci_pkg::in_t mk(input plci_pkg::cmd_e c, input logic [31:0] x,
                                       input logic [31:0] y,
                                       input logic [30:0] tol = '0,
                                       input logic [31:0] lo = '0,
                                       input logic [31:0] hi = '0);
    plci_pkg::in_t it;
    it.command    = c;
    it.x_value    = x;
    it.y_value    = y;
    it.tolerance  = tol;
    it.low_bound  = lo;
    it.high_bound = hi;
    return it;
  endfunction

  function automatic int pick_key;
    if (key_seen.size() == 0) return int'($urandom);
    return key_seen[$urandom_range(key_seen.size() - 1)];
  endfunction

  // mostly well-formed traffic on a near-monotonic curve, some noise
  function automatic plci_pkg::in_t random_item;
    plci_pkg::in_t it;
    int            sel, a, b, k;
    longint        lo, hi;
    it  = plci_pkg::in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom}));
    sel = $urandom_range(99);
    if (sel < 30) begin
      k = ($urandom_range(4) == 0) ? int'($urandom)
                                   : int'($urandom_range(0, 1 << 21)) - (1 << 20);
      it.command = plci_pkg::CMD_INSERT;
      it.x_value = k;
      it.y_value = ($urandom_range(9) < 7) ? 32'(2 * k + int'($urandom_range(0, 4095)))
                                           : $urandom;
      if (key_seen.size() < plci_pkg::MAX_POINTS) key_seen.push_back(k);
    end else if (sel < 60) begin
      it.command = plci_pkg::CMD_EVAL;
      a  = pick_key();
      b  = pick_key();
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      case ($urandom_range(2))
        0: it.x_value = a;
        1: it.x_value = 32'(lo + longint'($urandom) % (hi - lo + 1));
        default: ;
      endcase
    end else if (sel < 85) begin
      it.command    = plci_pkg::CMD_INVERT;
      it.low_bound  = pick_key();
      it.high_bound = pick_key();
      it.y_value    = ($urandom_range(1) == 0) ? 32'(2 * pick_key()) : $urandom;
      it.tolerance  = ($urandom_range(15) == 0) ? 31'd0
                                                : 31'(1 << $urandom_range(8, 30));
    end else if (sel < 90) begin
      it.command = plci_pkg::CMD_NONE;
    end
    return it;
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty and sparse table, saturation, extreme keys
    idle_pct = 0;
    send_cmd(mk(plci_pkg::CMD_NONE, 32'hffff_ffff, 32'hffff_ffff, '1, '1, '1));
    send_cmd(mk(plci_pkg::CMD_EVAL, 32'h0, 32'h0));
    send_cmd(mk(plci_pkg::CMD_INVERT, 32'h0, 32'h0, 31'h1, -32'sd5, 32'd7));
    send_cmd(mk(plci_pkg::CMD_INSERT, 32'h0001_0000, 32'h0002_0000));
    send_cmd(mk(plci_pkg::CMD_EVAL, 32'h0001_0000, 32'h0));
    send_cmd(mk(plci_pkg::CMD_INSERT, 32'h0001_0000, 32'h5));
    send_cmd(mk(plci_pkg::CMD_INSERT, 32'hffff_0000, 32'h8000_0000));
    send_cmd(mk(plci_pkg::CMD_EVAL, 32'h0001_0000, 32'h0));
    send_cmd(mk(plci_pkg::CMD_EVAL, 32'h0, 32'h0));
    send_cmd(mk(plci_pkg::CMD_EVAL, 32'h8000_0000, 32'h0));
    send_cmd(mk(plci_pkg::CMD_EVAL, 32'h0002_0000, 32'h0));
    send_cmd(mk(plci_pkg::CMD_INSERT, 32'h7fff_0000, 32'h7fff_ffff));
    send_cmd(mk(plci_pkg::CMD_EVAL, 32'h4000_0000, 32'h0));
    send_cmd(mk(plci_pkg::CMD_INVERT, 32'h0, 32'h0, 31'h7fff_ffff, 32'hffff_0000,
                32'h0001_0000));
    send_cmd(mk(plci_pkg::CMD_INVERT, 32'h0, 32'h0001_8000, 31'h0, 32'hffff_0000,
                32'h7fff_0000));
    send_cmd(mk(plci_pkg::CMD_INVERT, 32'h0, 32'h0, 31'h100, 32'h0, 32'h7fff_ffff));
    send_cmd(mk(plci_pkg::CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff));
    send_cmd(mk(plci_pkg::CMD_EVAL, 32'h8000_0000, 32'h0));
    send_cmd(mk(plci_pkg::CMD_EVAL, 32'h7fff_ffff, 32'h0));
    send_cmd(mk(plci_pkg::CMD_INVERT, 32'h0, 32'h7fff_ffff, 31'h1, 32'h8000_0000,
                32'h7fff_0000));
    key_seen = '{32'h0001_0000, 32'hffff_0000, 32'h7fff_0000, 32'h8000_0000};
    drain();

    // random traffic, three sender idling profiles
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 10 : (phase == 1) ? 74 : 0;
      if (phase == 2) send_cmd(mk(plci_pkg::CMD_INSERT, 32'h7fff_ffff, 32'h0));
      for (int i = 0; i < PHASE_ITEMS; i++) send_cmd(random_item());
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("covered %0d inserts, %0d evaluates, %0d inverts, %0d unused commands",
             cmd_count[plci_pkg::CMD_INSERT], cmd_count[plci_pkg::CMD_EVAL],
             cmd_count[plci_pkg::CMD_INVERT], cmd_count[plci_pkg::CMD_NONE]);
    $display("%0d result beats compared, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
